// ----- hw/rtl/bma_pkg.sv -----
// Package for the bit manipulation ALU: operation codes, widths and the
// structs carried between pipeline stages. No dependencies.
`timescale 1ns / 1ps

package bma_pkg;

   localparam int WORD_W = 32;
   localparam int IMM_W  = 16;
   localparam int AMT_W  = 5;
   localparam int GRP_N  = 4;   // byte groups for the leading-bit count
   localparam int CLS_W  = 6;   // holds a count of 0..32

   typedef enum logic [2:0] {
      FN_ADD  = 3'd0,
      FN_AND  = 3'd1,
      FN_PDEP = 3'd2,
      FN_CLS  = 3'd3,
      FN_ROR  = 3'd4,
      FN_SLTI = 3'd5,
      FN_SAT  = 3'd6,
      FN_NONE = 3'd7
   } func_type;

   // Captured request.
   typedef struct packed {
      func_type                  func;
      logic [WORD_W-1:0]         op_a;
      logic [WORD_W-1:0]         op_b;
      logic signed [IMM_W-1:0]   immediate;
      logic [AMT_W-1:0]          amount;
   } req_type;

   // Partial results handed from the prepare stage to the final stage.
   typedef struct packed {
      func_type                      func;
      logic [WORD_W-1:0]             op_a;
      logic [WORD_W-1:0]             mask;
      logic [WORD_W-1:0][AMT_W-1:0]  rank;     // set mask bits below each position
      logic [GRP_N-1:0][3:0]         grp_clz;  // leading zeros inside each byte
      logic [GRP_N-1:0]              grp_nz;
      logic                          sat_ovf;
      logic [WORD_W-1:0]             sat_lo;   // most negative value in range
      logic [WORD_W-1:0]             simple;   // add, and, rotate, compare, zero
   } prep_type;

endpackage

// ----- hw/rtl/bma_prep.sv -----
// Prepare stage of the bit manipulation ALU: simple operations, deposit
// ranks, per-byte leading counts and the saturation overflow test. Uses bma_pkg.
`timescale 1ns / 1ps

module bma_prep
   import bma_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output prep_type out_prep
);

   logic     valid_ff;
   prep_type prep_ff;
   prep_type prep_in;

   logic [WORD_W-1:0]        lead_w;
   logic [2*WORD_W-1:0]      ror_w;
   logic signed [WORD_W-1:0] sat_upper;
   logic [AMT_W-1:0]         sat_sh;

   always_comb begin
      prep_in        = '0;
      prep_in.func   = in_req.func;
      prep_in.op_a   = in_req.op_a;
      prep_in.mask   = in_req.op_b;

      // Rank of each mask position: independent popcounts of the bits below.
      for (int i = 0; i < WORD_W; i++) begin
         prep_in.rank[i] = AMT_W'($countones(in_req.op_b &
                                             ((WORD_W'(1) << i) - WORD_W'(1))));
      end

      // Bits that differ from the sign, with a stop bit at the bottom.
      lead_w = {in_req.op_a[WORD_W-2:0] ^ {(WORD_W-1){in_req.op_a[WORD_W-1]}}, 1'b1};
      for (int g = 0; g < GRP_N; g++) begin
         prep_in.grp_nz[g]  = |lead_w[8*g +: 8];
         prep_in.grp_clz[g] = 4'd8;
         for (int j = 0; j < 8; j++) begin
            if (lead_w[8*g + j]) prep_in.grp_clz[g] = 4'(7 - j);
         end
      end

      // Saturation: out of range when the bits from the field's sign bit upward disagree.
      sat_sh         = in_req.amount - AMT_W'(1);
      sat_upper      = $signed(in_req.op_a) >>> sat_sh;
      prep_in.sat_ovf = (in_req.amount != '0) && (sat_upper != '0) && (sat_upper != '1);
      prep_in.sat_lo = {WORD_W{1'b1}} << sat_sh;

      ror_w = {in_req.op_a, in_req.op_a} >> in_req.amount;

      case (in_req.func)
         FN_ADD:  prep_in.simple = in_req.op_a + in_req.op_b;
         FN_AND:  prep_in.simple = in_req.op_a & in_req.op_b;
         FN_ROR:  prep_in.simple = ror_w[WORD_W-1:0];
         FN_SLTI: prep_in.simple = WORD_W'($signed(in_req.op_a) <
                                          WORD_W'(in_req.immediate));
         default: prep_in.simple = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign out_valid = valid_ff;
   assign out_prep  = prep_ff;

endmodule

// ----- hw/rtl/bma_final.sv -----
// Final stage of the bit manipulation ALU: deposit select, sign-bit count
// merge, saturation pick and result select. Uses bma_pkg.
`timescale 1ns / 1ps

module bma_final
   import bma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  prep_type          in_prep,
   output logic              out_valid,
   output logic [WORD_W-1:0] out_result
);

   logic              valid_ff;
   logic [WORD_W-1:0] result_ff;
   logic [WORD_W-1:0] result_in;
   logic [WORD_W-1:0] pdep;
   logic [CLS_W-1:0]  lead;
   logic [CLS_W-1:0]  cls;
   logic [WORD_W-1:0] sat;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         pdep[i] = in_prep.mask[i] & in_prep.op_a[in_prep.rank[i]];
      end

      // Highest nonzero byte wins; the bottom byte always holds the stop bit.
      lead = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (in_prep.grp_nz[g]) begin
            lead = CLS_W'(8 * (GRP_N - 1 - g)) + CLS_W'(in_prep.grp_clz[g]);
         end
      end
      cls = (lead >= CLS_W'(WORD_W - 2)) ? CLS_W'(WORD_W - 1) : lead + CLS_W'(1);

      if (!in_prep.sat_ovf) begin
         sat = in_prep.op_a;
      end else if (in_prep.op_a[WORD_W-1]) begin
         sat = in_prep.sat_lo;
      end else begin
         sat = ~in_prep.sat_lo;
      end

      case (in_prep.func)
         FN_PDEP: result_in = pdep;
         FN_CLS:  result_in = WORD_W'(cls);
         FN_SAT:  result_in = sat;
         default: result_in = in_prep.simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ----- hw/rtl/bit_manipulation_alu.sv -----
// Top level of the bit manipulation ALU: request capture register and the
// prepare and final stages. Depends on bma_pkg, bma_prep and bma_final.
`timescale 1ns / 1ps

// Three-stage execute unit. busy is always low, so a request is taken in
// every cycle that start is high, and its result appears on rsp_result with
// rsp_strobe, in request order. The rate is one request per clock; each
// request passes through the three register stages: request capture,
// prepare (adder, rotator, deposit ranks, per-byte leading-bit counts,
// saturation range test) and final select. The receiver cannot stall, and
// none is needed: nothing inside ever holds back.
module bit_manipulation_alu
   import bma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_func,
   input  logic [WORD_W-1:0]       req_op_a,
   input  logic [WORD_W-1:0]       req_op_b,
   input  logic signed [IMM_W-1:0] req_immediate,
   input  logic [AMT_W-1:0]        req_amount,
   output logic                    rsp_strobe,
   output logic [WORD_W-1:0]       rsp_result
);

   logic     req_valid_ff;
   req_type  req_ff;
   req_type  req_in;
   logic     prep_valid;
   prep_type prep;

   // Never hold off a request: every stage advances each cycle.
   assign busy = 1'b0;

   always_comb begin
      req_in.func      = func_type'(req_func);
      req_in.op_a      = req_op_a;
      req_in.op_b      = req_op_b;
      req_in.immediate = req_immediate;
      req_in.amount    = req_amount;
   end

   // Capture the request; the valid bit travels with it down the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   bma_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid_ff),
      .in_req   (req_ff),
      .out_valid(prep_valid),
      .out_prep (prep)
   );

   bma_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_prep   (prep),
      .out_valid (rsp_strobe),
      .out_result(rsp_result)
   );

   // Every accepted request yields a result with rsp_strobe.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("accepted request produced no result");

   // A strobe only follows an accepted request.
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(prep_valid))
      else $error("result strobe without a request");

   // The unused code yields zero.
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FN_NONE) |-> ##3 (rsp_result == '0))
      else $error("unused operation code gave nonzero result");

   // Compare gives only 0 or 1.
   a_slti_bool : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FN_SLTI) |-> ##3 (rsp_result[WORD_W-1:1] == '0))
      else $error("set-less-than result out of range");

endmodule

// ----- verif/tb_bit_manipulation_alu.sv -----
// Self-checking testbench for bit_manipulation_alu: directed and random requests
// checked against an in-bench model of every operation.
// Depends on bma_pkg and the bit_manipulation_alu RTL.
`timescale 1ns / 1ps

module tb_bit_manipulation_alu;
   import bma_pkg::*;

   localparam int CLK_HALF      = 4;     // 8 ns period
   localparam int RANDOM_COUNT  = 550;
   localparam int DRAIN_CYCLES  = 8;     // margin for stray strobes after the last result
   localparam int STALL_LIMIT   = 1000;  // cycles with no request and no result
   localparam int IDLE_PERCENT  = 37;
   localparam int BURST_FIRST   = 200;   // requests in this window are sent back to back
   localparam int BURST_LAST    = 330;

   // One expected result together with the request that caused it,
   // kept so that a mismatch line can show the operands.
   typedef struct {
      req_type     req;
      logic [31:0] result;
   } alu_expect_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_func = '0;
   logic [WORD_W-1:0]       req_op_a = '0;
   logic [WORD_W-1:0]       req_op_b = '0;
   logic signed [IMM_W-1:0] req_immediate = '0;
   logic [AMT_W-1:0]        req_amount = '0;
   logic                    rsp_strobe;
   logic [WORD_W-1:0]       rsp_result;

   req_type        request_queue[$];    // requests not yet offered to the block
   alu_expect_type pending_results[$];  // results owed by the block, oldest first
   int             mismatch_count = 0;
   int             accepted_count = 0;
   int             stall_cycles   = 0;

   bit_manipulation_alu uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_op_a      (req_op_a),
      .req_op_b      (req_op_b),
      .req_immediate (req_immediate),
      .req_amount    (req_amount),
      .rsp_strobe    (rsp_strobe),
      .rsp_result    (rsp_result)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // Model of the execute unit: one 32-bit result per request.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] compute_alu_result(input req_type r);
      logic [31:0] res;
      logic [63:0] doubled;
      longint      val;
      longint      lo;
      longint      hi;
      int          k;
      int          n;
      res = '0;
      case (r.func)
         FN_ADD:  res = r.op_a + r.op_b;
         FN_AND:  res = r.op_a & r.op_b;
         FN_PDEP: begin
            // Walk the mask upward; each set position takes the next low bit of A.
            k = 0;
            for (int i = 0; i < WORD_W; i++) begin
               if (r.op_b[i]) begin
                  res[i] = r.op_a[k];
                  k++;
               end
            end
         end
         FN_CLS: begin
            // Count from the top while bits match the sign; cap at 31.
            n = 0;
            for (int i = WORD_W - 1; i >= 0; i--) begin
               if (r.op_a[i] != r.op_a[WORD_W-1])
                  break;
               n++;
            end
            if (n > 31)
               n = 31;
            res = n;
         end
         FN_ROR: begin
            doubled = {r.op_a, r.op_a} >> r.amount;
            res = doubled[31:0];
         end
         FN_SLTI: begin
            val = $signed(r.op_a);
            lo  = $signed(r.immediate);
            res = (val < lo) ? 32'd1 : 32'd0;
         end
         FN_SAT: begin
            // Width zero passes A through; otherwise clamp to a signed field.
            if (r.amount == 0) begin
               res = r.op_a;
            end else begin
               hi  = (longint'(1) << (r.amount - 1)) - 1;
               lo  = -hi - 1;
               val = $signed(r.op_a);
               if (val < lo)
                  val = lo;
               if (val > hi)
                  val = hi;
               res = 32'(val);
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic add_request(input func_type f, input logic [31:0] a, input logic [31:0] b,
                              input logic signed [15:0] imm, input logic [4:0] amt);
      req_type r;
      r.func      = f;
      r.op_a      = a;
      r.op_b      = b;
      r.immediate = imm;
      r.amount    = amt;
      request_queue.push_back(r);
   endtask

   // Operand picker: full-range words, plus extremes, small magnitudes
   // and values right at the saturation bounds for the given width.
   function automatic logic [31:0] pick_word(input logic [4:0] amt);
      logic [31:0] w;
      logic [31:0] edge_val;
      case ($urandom_range(0, 5))
         0, 1: w = $urandom();
         2: begin
            case ($urandom_range(0, 3))
               0:       w = 32'h0000_0000;
               1:       w = 32'hFFFF_FFFF;
               2:       w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         end
         3: w = $urandom_range(0, 300);
         4: w = 32'(-int'($urandom_range(1, 300)));
         default: begin
            edge_val = (amt == 0) ? 32'h0 : (32'd1 << (amt - 1));
            if ($urandom_range(0, 1))
               edge_val = -edge_val;
            w = edge_val + 32'(int'($urandom_range(0, 3)) - 2);
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [15:0] pick_immediate();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         default: return IMM_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: hold the current request until accepted, then advance or idle.
   // busy is sampled before the edge updates, so acceptance is unambiguous.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alu_expect_type exp_item;
      req_type        next_req;
      logic           idle_now;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            exp_item.req.func      = func_type'(req_func);
            exp_item.req.op_a      = req_op_a;
            exp_item.req.op_b      = req_op_b;
            exp_item.req.immediate = req_immediate;
            exp_item.req.amount    = req_amount;
            exp_item.result        = compute_alu_result(exp_item.req);
            pending_results.push_back(exp_item);
            accepted_count++;
         end
         // Hold a request the block has not taken yet; otherwise pick the next.
         if (!(start && busy)) begin
            idle_now = (accepted_count < BURST_FIRST || accepted_count >= BURST_LAST)
                       && ($urandom_range(0, 99) < IDLE_PERCENT);
            if (request_queue.size() != 0 && !idle_now) begin
               next_req = request_queue.pop_front();
               req_func      <= next_req.func;
               req_op_a      <= next_req.op_a;
               req_op_b      <= next_req.op_b;
               req_immediate <= next_req.immediate;
               req_amount    <= next_req.amount;
               start         <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobe must match the oldest outstanding result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alu_expect_type exp_item;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h with nothing outstanding",
                                      rsp_result));
         end else begin
            exp_item = pending_results.pop_front();
            if (rsp_result !== exp_item.result)
               report_mismatch($sformatf(
                  "func=%0d a=%h b=%h imm=%0d amt=%0d: result %h, expected %h",
                  exp_item.req.func, exp_item.req.op_a, exp_item.req.op_b,
                  exp_item.req.immediate, exp_item.req.amount,
                  rsp_result, exp_item.result));
         end
      end
   end

   // Watchdog: drop the run if neither side moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("tb_bit_manipulation_alu NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      req_type r;
      // Directed: extremes of each operation.
      add_request(FN_ADD,  32'hFFFF_FFFF, 32'h0000_0001, 16'sh0000, 5'd0);   // wraps to zero
      add_request(FN_ADD,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sh7FFF, 5'd31);
      add_request(FN_AND,  32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'sh8000, 5'd17);
      add_request(FN_PDEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh0000, 5'd0);
      add_request(FN_PDEP, 32'h0000_1234, 32'h0000_0000, 16'sh0000, 5'd0);   // empty mask
      add_request(FN_PDEP, 32'h0000_0002, 32'h8000_0001, 16'sh0000, 5'd0);
      add_request(FN_PDEP, 32'h0000_00B5, 32'hF0F0_F0F0, 16'sh0000, 5'd0);
      add_request(FN_CLS,  32'h0000_0000, 32'h0000_0000, 16'sh0000, 5'd0);   // capped
      add_request(FN_CLS,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh0000, 5'd0);   // capped
      add_request(FN_CLS,  32'h8000_0000, 32'h0000_0000, 16'sh0000, 5'd0);
      add_request(FN_CLS,  32'h4000_0000, 32'h0000_0000, 16'sh0000, 5'd0);
      add_request(FN_CLS,  32'h0000_0001, 32'h0000_0000, 16'sh0000, 5'd0);
      add_request(FN_ROR,  32'h8000_0001, 32'h0000_0000, 16'sh0000, 5'd0);   // no rotation
      add_request(FN_ROR,  32'h8000_0001, 32'h0000_0000, 16'sh0000, 5'd1);
      add_request(FN_ROR,  32'h1234_5678, 32'h0000_0000, 16'sh0000, 5'd31);
      add_request(FN_SLTI, 32'h8000_0000, 32'h0000_0000, 16'sh8000, 5'd0);
      add_request(FN_SLTI, 32'hFFFF_7FFF, 32'h0000_0000, 16'sh8000, 5'd0);
      add_request(FN_SLTI, 32'hFFFF_8000, 32'h0000_0000, 16'sh8000, 5'd0);
      add_request(FN_SLTI, 32'h0000_7FFE, 32'h0000_0000, 16'sh7FFF, 5'd0);
      add_request(FN_SAT,  32'h8000_0000, 32'h0000_0000, 16'sh0000, 5'd0);   // width zero
      add_request(FN_SAT,  32'h0000_0005, 32'h0000_0000, 16'sh0000, 5'd1);
      add_request(FN_SAT,  32'hFFFF_FFFF, 32'h0000_0000, 16'sh0000, 5'd1);
      add_request(FN_SAT,  32'h8000_0000, 32'h0000_0000, 16'sh0000, 5'd31);
      add_request(FN_SAT,  32'h7FFF_FFFF, 32'h0000_0000, 16'sh0000, 5'd31);
      add_request(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'shFFFF, 5'd31);  // unused code

      // Random: all codes, operands biased toward edges and boundaries.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         r.func      = func_type'($urandom_range(0, 7));
         r.amount    = AMT_W'($urandom_range(0, 31));
         r.immediate = pick_immediate();
         r.op_a      = pick_word(r.amount);
         r.op_b      = ($urandom_range(0, 3) == 0) ? pick_word(r.amount) : $urandom();
         // Put A right around the immediate so the compare flips both ways.
         if (r.func == FN_SLTI && $urandom_range(0, 1))
            r.op_a = 32'(int'(r.immediate) + int'($urandom_range(0, 4)) - 2);
         request_queue.push_back(r);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to go in, then for every result to return.
      while (request_queue.size() != 0 || start)
         @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      // Leave room for any stray strobe after the last expected result.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (mismatch_count == 0) begin
         $display("tb_bit_manipulation_alu OK");
      end else begin
         $display("tb_bit_manipulation_alu NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bma_pkg.sv
hw/rtl/bma_prep.sv
hw/rtl/bma_final.sv
hw/rtl/bit_manipulation_alu.sv
verif/tb_bit_manipulation_alu.sv
